/* design/sccb_pkg.sv */
// ----------------------------------------------------------------------------
// sccb_pkg
// shared types and constants of the two-wire camera bus master
// ----------------------------------------------------------------------------
package sccb_pkg;

   localparam int PHASE_W    = 16;
   localparam int CMD_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int STEP_W     = 5;

   localparam logic [PHASE_W-1:0]    PHASE_CLOCKS_RESET = 16'd100;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PHASE_CLOCKS  = 3'd0;

   // step numbers inside one run
   localparam logic [STEP_W-1:0] STEP_BITS_END  = 5'd24;
   localparam logic [STEP_W-1:0] STEP_IDLE_TAIL = 5'd24;
   localparam logic [STEP_W-1:0] STEP_RELEASE   = 5'd25;
   localparam logic [STEP_W-1:0] STEP_ACK_HIGH  = 5'd26;
   localparam logic [STEP_W-1:0] STEP_ACK_LOW   = 5'd27;
   localparam logic [STEP_W-1:0] STEP_READ_LAST = 5'd24;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 3'd0,
      CMD_STOP  = 3'd1,
      CMD_NOACK = 3'd2,
      CMD_WBYTE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_WWORD = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_WAIT,
      ST_SEND
   } state_type;

endpackage

/* design/sccb_bus_master.sv */
// ----------------------------------------------------------------------------
// sccb_bus_master
// two-wire camera bus master producing one beat per pin phase
// ----------------------------------------------------------------------------
// Each accepted command expands into a run of pin phases (start 4, stop 3,
// no-ack 4, write byte 28, read byte 25, write word 56 or 28 when the first
// byte is not acknowledged); one result beat per phase, tlast on the final
// one. A phase first sets the pins, then counts phase_clocks down in the phase
// timer (a value of 0 counts as 1), then its beat waits for rsp_tready. The
// input stays not ready until the run has been delivered; unknown command
// types are accepted and give no beats.
module sccb_bus_master (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [23:0]                        req_tdata,  // tx_data, line_samples
   input  logic [sccb_pkg::CMD_W-1:0]         req_tuser,  // req_type
   // phase channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,  // scl_level, sda_level,
                                                          // sda_drive, rx_byte, ack_ok
   output logic                               rsp_tlast,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sccb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sccb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sccb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import sccb_pkg::*;

   logic [PHASE_W-1:0] phase_clocks;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [1:0]         sub_ff, sub_in;
   logic               second_ff, second_in;
   logic [WORD_W-1:0]  shift_ff, shift_in;
   logic [BYTE_W-1:0]  smp_ff, smp_in;
   logic [BYTE_W-1:0]  rx_ff, rx_in;
   logic               ack_ff, ack_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               drv_ff, drv_in;
   logic [PHASE_W-1:0] timer_ff, timer_in;
   logic               out_scl_ff, out_scl_in;
   logic               out_sda_ff, out_sda_in;
   logic               out_drv_ff, out_drv_in;
   logic               out_last_ff, out_last_in;
   logic [BYTE_W-1:0]  out_rx_ff, out_rx_in;
   logic               out_ack_ff, out_ack_in;

   logic               is_last;
   logic               is_write;
   logic               timer_done;
   logic               known_cmd;

   sccb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .phase_clocks (phase_clocks)
   );

   assign is_write   = (cmd_ff == CMD_WBYTE) || (cmd_ff == CMD_WWORD);
   assign timer_done = (timer_ff <= PHASE_W'(1));
   assign known_cmd  = (req_tuser <= CMD_WWORD);

   always_comb begin
      case (cmd_ff)
         CMD_START: is_last = (step_ff == 5'd3);
         CMD_STOP:  is_last = (step_ff == 5'd2);
         CMD_NOACK: is_last = (step_ff == 5'd3);
         CMD_WBYTE: is_last = (step_ff == STEP_ACK_LOW);
         CMD_READ:  is_last = (step_ff == STEP_READ_LAST);
         CMD_WWORD: is_last = (step_ff == STEP_ACK_LOW) && (second_ff || !ack_ff);
         default:   is_last = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && known_cmd) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: state_in = ST_WAIT;
         ST_WAIT: begin
            if (timer_done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_tready) begin
               state_in = is_last ? ST_IDLE : ST_APPLY;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_SEND);
   end

   // sequencer datapath
   always_comb begin
      cmd_in      = cmd_ff;
      step_in     = step_ff;
      sub_in      = sub_ff;
      second_in   = second_ff;
      shift_in    = shift_ff;
      smp_in      = smp_ff;
      rx_in       = rx_ff;
      ack_in      = ack_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      drv_in      = drv_ff;
      timer_in    = timer_ff;
      out_scl_in  = out_scl_ff;
      out_sda_in  = out_sda_ff;
      out_drv_in  = out_drv_ff;
      out_last_in = out_last_ff;
      out_rx_in   = out_rx_ff;
      out_ack_in  = out_ack_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd_in    = cmd_type'(req_tuser);
            step_in   = '0;
            sub_in    = '0;
            second_in = 1'b0;
            rx_in     = '0;
            ack_in    = 1'b0;
            smp_in    = req_tdata[23:16];
            if (req_tuser == CMD_WBYTE) begin
               shift_in = {req_tdata[7:0], 8'h00};
            end else begin
               shift_in = req_tdata[15:0];
            end
         end
         ST_APPLY: begin
            timer_in = (phase_clocks == '0) ? PHASE_W'(1) : phase_clocks;
            case (cmd_ff)
               CMD_START: begin
                  case (step_ff)
                     5'd0: begin
                        drv_in = 1'b1;
                        sda_in = 1'b1;
                     end
                     5'd1:    scl_in = 1'b1;
                     5'd2:    sda_in = 1'b0;
                     default: scl_in = 1'b0;
                  endcase
               end
               CMD_STOP: begin
                  case (step_ff)
                     5'd0:    sda_in = 1'b0;
                     5'd1:    scl_in = 1'b1;
                     default: sda_in = 1'b1;
                  endcase
               end
               CMD_NOACK: begin
                  case (step_ff)
                     5'd0:    sda_in = 1'b1;
                     5'd1:    scl_in = 1'b1;
                     5'd2:    scl_in = 1'b0;
                     default: sda_in = 1'b0;
                  endcase
               end
               CMD_READ: begin
                  if (step_ff == '0) begin
                     drv_in = 1'b0;
                  end else if (sub_ff == 2'd1) begin
                     scl_in = 1'b1;
                  end else if (sub_ff == 2'd2) begin
                     rx_in  = {rx_ff[BYTE_W-2:0], smp_ff[0]};
                     smp_in = {1'b0, smp_ff[BYTE_W-1:1]};
                     scl_in = 1'b0;
                  end
               end
               default: begin
                  // write byte and write word share the octet sequence
                  if (step_ff < STEP_BITS_END) begin
                     case (sub_ff)
                        2'd0: begin
                           sda_in   = shift_ff[WORD_W-1];
                           shift_in = {shift_ff[WORD_W-2:0], 1'b0};
                        end
                        2'd1:    scl_in = 1'b1;
                        default: scl_in = 1'b0;
                     endcase
                  end else begin
                     case (step_ff)
                        STEP_IDLE_TAIL: ;
                        STEP_RELEASE:   drv_in = 1'b0;
                        STEP_ACK_HIGH:  scl_in = 1'b1;
                        default: begin
                           ack_in = ~smp_ff[0];
                           smp_in = {1'b0, smp_ff[BYTE_W-1:1]};
                           scl_in = 1'b0;
                        end
                     endcase
                  end
               end
            endcase
         end
         ST_WAIT: begin
            timer_in = timer_ff - PHASE_W'(1);
            if (timer_done) begin
               out_scl_in  = scl_ff;
               out_sda_in  = sda_ff;
               out_drv_in  = drv_ff;
               out_last_in = is_last;
               out_rx_in   = ((cmd_ff == CMD_READ) && is_last) ? rx_ff : '0;
               out_ack_in  = is_write && is_last && ack_ff;
            end
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (is_last) begin
                  if (is_write || (cmd_ff == CMD_READ)) begin
                     drv_in = 1'b1;
                  end
               end else if (is_write && (step_ff == STEP_ACK_LOW)) begin
                  // second byte of a word write
                  drv_in    = 1'b1;
                  step_in   = '0;
                  sub_in    = '0;
                  second_in = 1'b1;
               end else begin
                  step_in = step_ff + STEP_W'(1);
                  if (!((cmd_ff == CMD_READ) && (step_ff == '0))) begin
                     sub_in = (sub_ff == 2'd2) ? 2'd0 : sub_ff + 2'd1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         drv_ff   <= drv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      step_ff     <= step_in;
      sub_ff      <= sub_in;
      second_ff   <= second_in;
      shift_ff    <= shift_in;
      smp_ff      <= smp_in;
      rx_ff       <= rx_in;
      ack_ff      <= ack_in;
      timer_ff    <= timer_in;
      out_scl_ff  <= out_scl_in;
      out_sda_ff  <= out_sda_in;
      out_drv_ff  <= out_drv_in;
      out_last_ff <= out_last_in;
      out_rx_ff   <= out_rx_in;
      out_ack_ff  <= out_ack_in;
   end

   assign rsp_tdata = {4'b0000, out_ack_ff, out_rx_ff, out_drv_ff, out_sda_ff, out_scl_ff};
   assign rsp_tlast = out_last_ff;

`ifndef SYNTHESIS
   // a finished run frees the command side
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("command side not free after last beat");

   // a known command blocks further commands while it runs
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser <= CMD_WWORD) |=> !req_tready)
      else $error("command taken while a run is busy");

   // read byte only on the closing beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[10:3] == 8'h00) && !rsp_tdata[11])
      else $error("read byte or ack flag outside the last beat");
`endif

endmodule

/* design/sccb_csr.sv */
// ----------------------------------------------------------------------------
// sccb_csr
// register file of the camera bus master: phase hold time
// ----------------------------------------------------------------------------
module sccb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sccb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sccb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sccb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [sccb_pkg::PHASE_W-1:0]       phase_clocks
);
   import sccb_pkg::*;

   logic [PHASE_W-1:0] phase_clocks_ff;
   logic [PHASE_W-1:0] phase_clocks_in;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                  (csr_paddr == ADDR_PHASE_CLOCKS);

   always_comb begin
      phase_clocks_in = phase_clocks_ff;
      if (wr_en) begin
         phase_clocks_in = csr_pwdata[PHASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_clocks_ff <= PHASE_CLOCKS_RESET;
      end else begin
         phase_clocks_ff <= phase_clocks_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_PHASE_CLOCKS) begin
         csr_prdata = {{(CSR_DATA_W-PHASE_W){1'b0}}, phase_clocks_ff};
      end
   end

   assign phase_clocks = phase_clocks_ff;

endmodule

/* tb/sccb_bus_master_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sccb_bus_master_checker
// phase predictor and scoreboard for the camera bus master
// ----------------------------------------------------------------------------
// Watches the command, phase and register channels. Every accepted command is
// expanded into the pin phases it should produce, using a local copy of the
// line state. Each phase beat is compared with the oldest expected phase.
// Register reads are checked against a local copy of phase_clocks.
// ----------------------------------------------------------------------------
module sccb_bus_master_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [23:0]                     req_tdata,
   input  logic [sccb_pkg::CMD_W-1:0]      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [15:0]                     rsp_tdata,
   input  logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sccb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sccb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [sccb_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                            csr_pready,
   output int                              failures,
   output int                              pending_beats,
   output int                              beats_seen
);
   import sccb_pkg::*;

   typedef struct packed {
      logic              scl;
      logic              sda;
      logic              drive;
      logic              last;
      logic [BYTE_W-1:0] rx;
      logic              ack;
   } phase_beat_type;

   phase_beat_type     expected_phases[$];
   phase_beat_type     run_phases[$];
   logic               scl_line;
   logic               sda_out;
   logic               sda_en;
   logic [PHASE_W-1:0] phase_time;

   task automatic emit_phase();
      phase_beat_type b;
      b       = '0;
      b.scl   = scl_line;
      b.sda   = sda_out;
      b.drive = sda_en;
      run_phases.push_back(b);
   endtask

   task automatic shift_octet(input logic [BYTE_W-1:0] octet, input logic sample,
                              output logic acked);
      int i;
      for (i = BYTE_W - 1; i >= 0; i--) begin
         sda_out = octet[i];
         emit_phase();
         scl_line = 1'b1;
         emit_phase();
         scl_line = 1'b0;
         emit_phase();
      end
      emit_phase();
      sda_en = 1'b0;
      emit_phase();
      scl_line = 1'b1;
      emit_phase();
      acked    = !sample;
      scl_line = 1'b0;
      emit_phase();
      // drive comes back at once, seen in the next command's first phase
      sda_en = 1'b1;
   endtask

   task automatic expand_command(input logic [CMD_W-1:0] kind, input logic [WORD_W-1:0] word,
                                 input logic [BYTE_W-1:0] samples);
      int                i;
      logic              ack;
      logic              ack2;
      logic [BYTE_W-1:0] rx;
      phase_beat_type    tail;
      ack  = 1'b0;
      ack2 = 1'b0;
      rx   = '0;
      run_phases.delete();
      case (kind)
         CMD_START: begin
            sda_en  = 1'b1;
            sda_out = 1'b1;
            emit_phase();
            scl_line = 1'b1;
            emit_phase();
            sda_out = 1'b0;
            emit_phase();
            scl_line = 1'b0;
            emit_phase();
         end
         CMD_STOP: begin
            sda_out = 1'b0;
            emit_phase();
            scl_line = 1'b1;
            emit_phase();
            sda_out = 1'b1;
            emit_phase();
         end
         CMD_NOACK: begin
            sda_out = 1'b1;
            emit_phase();
            scl_line = 1'b1;
            emit_phase();
            scl_line = 1'b0;
            emit_phase();
            sda_out = 1'b0;
            emit_phase();
         end
         CMD_WBYTE: shift_octet(word[7:0], samples[0], ack);
         CMD_READ: begin
            sda_en = 1'b0;
            emit_phase();
            for (i = 0; i < BYTE_W; i++) begin
               emit_phase();
               scl_line = 1'b1;
               emit_phase();
               rx       = {rx[BYTE_W-2:0], samples[i]};
               scl_line = 1'b0;
               emit_phase();
            end
            sda_en = 1'b1;
         end
         CMD_WWORD: begin
            shift_octet(word[15:8], samples[0], ack);
            // no second byte after a refused first one
            if (ack) begin
               shift_octet(word[7:0], samples[1], ack2);
               ack = ack2;
            end
         end
         default: ;
      endcase
      if (run_phases.size() != 0) begin
         tail      = run_phases[run_phases.size()-1];
         tail.last = 1'b1;
         tail.rx   = (kind == CMD_READ) ? rx : '0;
         tail.ack  = (kind == CMD_WBYTE || kind == CMD_WWORD) && ack;
         run_phases[run_phases.size()-1] = tail;
         foreach (run_phases[k]) expected_phases.push_back(run_phases[k]);
      end
   endtask

   always @(posedge clock) begin
      phase_beat_type got;
      phase_beat_type want;
      if (reset) begin
         scl_line   = 1'b1;
         sda_out    = 1'b1;
         sda_en     = 1'b0;
         phase_time = PHASE_CLOCKS_RESET;
         expected_phases.delete();
         failures   = 0;
         beats_seen = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite && csr_paddr == ADDR_PHASE_CLOCKS)
               phase_time = csr_pwdata[PHASE_W-1:0];
            else if (!csr_pwrite && csr_paddr == ADDR_PHASE_CLOCKS &&
                     csr_prdata !== {{(CSR_DATA_W-PHASE_W){1'b0}}, phase_time}) begin
               $display("%0t: phase_clocks read back, expected %0d, got %0d",
                        $time, phase_time, csr_prdata);
               failures++;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            got.scl   = rsp_tdata[0];
            got.sda   = rsp_tdata[1];
            got.drive = rsp_tdata[2];
            got.rx    = rsp_tdata[10:3];
            got.ack   = rsp_tdata[11];
            got.last  = rsp_tlast;
            if (expected_phases.size() == 0) begin
               $display("%0t: unexpected phase beat, expected none,", $time,
                        " got scl=%0b sda=%0b drive=%0b last=%0b rx=%02h ack=%0b",
                        got.scl, got.sda, got.drive, got.last, got.rx, got.ack);
               failures++;
            end else begin
               want = expected_phases.pop_front();
               if (got !== want) begin
                  $display("%0t: phase mismatch,", $time,
                           " expected scl=%0b sda=%0b drive=%0b last=%0b rx=%02h ack=%0b,",
                           want.scl, want.sda, want.drive, want.last, want.rx, want.ack,
                           " got scl=%0b sda=%0b drive=%0b last=%0b rx=%02h ack=%0b",
                           got.scl, got.sda, got.drive, got.last, got.rx, got.ack);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expand_command(req_tuser, req_tdata[15:0], req_tdata[23:16]);
      end
      pending_beats = expected_phases.size();
   end

endmodule

/* tb/sccb_bus_master_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sccb_bus_master_tb
// command stimulus and verdict for the camera bus master
// ----------------------------------------------------------------------------
// A directed set covers every command, the byte extremes, refused acks, drive
// restore after reads and writes, reserved codes and released-line phases
// after reset. Random bus transactions follow at several phase times,
// including zero and one; one stop runs at the largest value. Both channels
// idle at random; the phase side holds off once for a long stretch. The
// checker compares every phase beat; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module sccb_bus_master_tb;
   import sccb_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
   localparam int SETTLE_CYCLES = 20;
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int HOLD_AFTER_BEATS = 1200;
   localparam int HOLD_CYCLES = 600;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [15:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int failures;
   int pending_beats;
   int beats_seen;
   int commands_sent;
   int reserved_sent;
   int settings_used;
   int idle_cycles;
   bit steady_send;

   sccb_bus_master DUT (.*);

   sccb_bus_master_checker checker_inst (.*);

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap(input bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ack slot low most of the time so word writes usually reach the low byte
   function automatic logic [BYTE_W-1:0] ack_samples();
      logic [BYTE_W-1:0] s;
      s    = BYTE_W'($urandom);
      s[0] = ($urandom_range(0, 9) == 0);
      s[1] = ($urandom_range(0, 9) == 0);
      return s;
   endfunction

   task automatic send_command(input logic [CMD_W-1:0] kind, input logic [WORD_W-1:0] word,
                               input logic [BYTE_W-1:0] samples);
      int gap;
      gap = pick_gap(steady_send);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {samples, word};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == CMD_RSVD_6 || kind == CMD_RSVD_7) reserved_sent++;
      else commands_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_beats != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_phase_time(input logic [PHASE_W-1:0] cycles);
      drain();
      csr_access(1'b1, ADDR_PHASE_CLOCKS, {{(CSR_DATA_W-PHASE_W){1'b0}}, cycles});
      csr_access(1'b0, ADDR_PHASE_CLOCKS, '0);
      settings_used++;
   endtask

   task automatic random_transaction();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 78) begin
         send_command(CMD_START, WORD_W'($urandom), BYTE_W'($urandom));
         send_command(CMD_WBYTE, WORD_W'($urandom), ack_samples());
         if ($urandom_range(0, 1) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               if ($urandom_range(0, 1) == 0)
                  send_command(CMD_WWORD, WORD_W'($urandom), ack_samples());
               else
                  send_command(CMD_WBYTE, WORD_W'($urandom), ack_samples());
            end
         end else begin
            send_command(CMD_START, WORD_W'($urandom), BYTE_W'($urandom));
            send_command(CMD_WBYTE, WORD_W'($urandom), ack_samples());
            n = $urandom_range(1, 3);
            repeat (n) send_command(CMD_READ, WORD_W'($urandom), BYTE_W'($urandom));
            send_command(CMD_NOACK, WORD_W'($urandom), BYTE_W'($urandom));
         end
         send_command(CMD_STOP, WORD_W'($urandom), BYTE_W'($urandom));
      end else begin
         send_command(CMD_W'($urandom_range(0, 7)), WORD_W'($urandom), BYTE_W'($urandom));
      end
   endtask

   task automatic random_block(input int count);
      int target;
      target      = commands_sent + count;
      steady_send = ($urandom_range(0, 3) == 0);
      while (commands_sent < target) random_transaction();
   endtask

   // phase side: random stalls, ready bursts, and one long hold-off
   initial begin
      int  r;
      int  stall;
      bit  held;
      rsp_tready = 1'b0;
      held       = 1'b0;
      forever begin
         @(negedge clock);
         r = $urandom_range(0, 99);
         if (!held && beats_seen >= HOLD_AFTER_BEATS) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (r < 4) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(50, 150)) @(negedge clock);
         end else begin
            stall = pick_gap(1'b0);
            rsp_tready <= (stall == 0);
            if (stall > 1) repeat (stall - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = CMD_START;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      commands_sent = 0;
      reserved_sent = 0;
      settings_used = 1;
      steady_send   = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      csr_access(1'b0, ADDR_PHASE_CLOCKS, '0);
      // line still released after reset
      send_command(CMD_STOP, 16'h0000, 8'h00);
      send_command(CMD_NOACK, 16'hFFFF, 8'hFF);
      send_command(CMD_RSVD_6, 16'hFFFF, 8'hFF);
      send_command(CMD_RSVD_7, 16'h0000, 8'h00);
      send_command(CMD_START, 16'h0000, 8'h00);
      send_command(CMD_WBYTE, 16'hFF00, 8'h00);
      send_command(CMD_WBYTE, 16'h00FF, 8'hFF);
      send_command(CMD_WBYTE, 16'h12A5, 8'hFE);
      send_command(CMD_WWORD, 16'hFFFF, 8'h00);
      send_command(CMD_WWORD, 16'h0000, 8'h01);
      send_command(CMD_WWORD, 16'h8001, 8'h02);
      send_command(CMD_WWORD, 16'h5AC3, 8'hFC);
      send_command(CMD_READ, 16'h0000, 8'h00);
      send_command(CMD_READ, 16'hFFFF, 8'hFF);
      send_command(CMD_READ, 16'h0000, 8'h01);
      // drive restore shows on the stop after a read
      send_command(CMD_STOP, 16'h0000, 8'h00);
      send_command(CMD_START, 16'hFFFF, 8'hFF);
      send_command(CMD_READ, 16'h0000, 8'hA5);
      send_command(CMD_NOACK, 16'h0000, 8'h00);
      send_command(CMD_WBYTE, 16'h0080, 8'h00);
      send_command(CMD_STOP, 16'hFFFF, 8'hFF);
      send_command(CMD_NOACK, 16'h0000, 8'h00);

      // zero behaves as a phase time of one
      set_phase_time(16'd0);
      random_block(60);
      set_phase_time(16'hFFFF);
      send_command(CMD_STOP, WORD_W'($urandom), BYTE_W'($urandom));
      set_phase_time(16'd1);
      random_block(60);
      repeat (3) begin
         set_phase_time(PHASE_W'($urandom_range(2, 12)));
         random_block(50);
      end
      drain();

      $display("covered %0d commands and %0d reserved codes, %0d phase beats checked,",
               commands_sent, reserved_sent, beats_seen);
      $display("over %0d phase time settings including 0, 1 and 65535",
               settings_used);
      if (failures == 0 && pending_beats == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
